@@ hw/rtl/scpa_pkg.sv @@
// shared types and codes for the size class pool allocator
// used by size_class_pool_allocator_unit and the testbench
package scpa_pkg;

  localparam int FieldW = 6;
  localparam int SizeW  = 16;
  localparam int StatW  = 2;

  localparam logic [StatW-1:0] ST_GRANTED = 2'd0;
  localparam logic [StatW-1:0] ST_NOSPACE = 2'd1;
  localparam logic [StatW-1:0] ST_FREED   = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_MOD  = 3'b100
  } state_t;

endpackage

@@ hw/rtl/scpa_first_set.sv @@
// lowest set bit finder: isolates the lowest one and encodes its position
// no package dependencies
module scpa_first_set #(
  parameter int W  = 64,
  parameter int IW = (W > 1) ? $clog2(W) : 1
) (
  input  logic [W-1:0]  vec,
  output logic          found,
  output logic [IW-1:0] idx,
  output logic [W-1:0]  onehot
);

  always_comb begin
    found  = |vec;
    // two's complement trick keeps only the lowest set bit
    onehot = vec & (~vec + W'(1));
    idx    = '0;
    for (int i = 0; i < W; i++) begin
      if (onehot[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

endmodule

@@ hw/rtl/size_class_pool_allocator_unit.sv @@
// Size class pool allocator. An allocate transaction rounds request_size up
// to a class of (k+1) << GRANULE_SHIFT bytes and grants the lowest free slot
// of the lowest non-full class at or above it; a free transaction clears one
// slot. Every transaction yields one result, loaded into the result register
// after acceptance: class pick from the class-full registers plus one read of
// the used map memory in S_LOOK, then first-free search and write back in
// S_MOD, held off while out_stall keeps a result waiting. No new transaction
// is accepted until the unit is back in S_IDLE, after the accept, the read and
// the write back of the single used map memory. Reset needs no clearing pass:
// per-row valid bits make unwritten rows read as free. Input is taken while a
// finished result still waits in the output register.
// depends on scpa_pkg and scpa_first_set
module size_class_pool_allocator_unit #(
  parameter int NUM_CLASSES     = 64,
  parameter int SLOTS_PER_CLASS = 64,
  parameter int GRANULE_SHIFT   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [scpa_pkg::SizeW-1:0]    request_size,
  input  logic [scpa_pkg::FieldW-1:0]   free_class,
  input  logic [scpa_pkg::FieldW-1:0]   free_slot,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [scpa_pkg::StatW-1:0]    status,
  output logic [scpa_pkg::FieldW-1:0]   grant_class,
  output logic [scpa_pkg::FieldW-1:0]   grant_slot
);

  import scpa_pkg::*;

  localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SW = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
  localparam int NW = 18;
  localparam logic [NW-1:0] GRAN_M1 = NW'((1 << GRANULE_SHIFT) - 1);

  state_t state;

  logic                  cmd_func;
  logic [SizeW-1:0]      cmd_size;
  logic [FieldW-1:0]     cmd_fcls;
  logic [FieldW-1:0]     cmd_fslot;

  logic [CW-1:0]         sel_class;
  logic                  sel_none;
  logic                  free_ok;
  logic [SW-1:0]         sel_slot;

  logic [NUM_CLASSES-1:0] class_full;
  logic [NUM_CLASSES-1:0] row_valid;

  logic [SLOTS_PER_CLASS-1:0] mem [NUM_CLASSES];
  logic [SLOTS_PER_CLASS-1:0] rd_data;

  // class pick
  logic [NW-1:0]          size_ext;
  logic [NW-1:0]          need;
  logic [NW-1:0]          k0;
  logic [NUM_CLASSES-1:0] avail;
  logic [NUM_CLASSES-1:0] cls_onehot;
  logic                   cls_found;
  logic [CW-1:0]          cls_idx;
  logic [8:0]             fcls_ext;
  logic [6:0]             fslot_ext;
  logic [CW-1:0]          rd_addr;

  // row modify
  logic [SLOTS_PER_CLASS-1:0] row;
  logic [SLOTS_PER_CLASS-1:0] slot_onehot;
  logic                       slot_found;
  logic [SW-1:0]              slot_idx;
  logic [SLOTS_PER_CLASS-1:0] free_dec;
  logic [SLOTS_PER_CLASS-1:0] wr_data;
  logic                       wr_en;
  logic                       mod_go;
  logic [8:0]                 cls_out_ext;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    size_ext = (cmd_size == '0) ? NW'(1) : NW'(cmd_size);
    need     = (size_ext + GRAN_M1) >> GRANULE_SHIFT;
    k0       = need - NW'(1);
    for (int i = 0; i < NUM_CLASSES; i++) begin
      avail[i] = (NW'(i) >= k0) && !class_full[i];
    end
  end

  scpa_first_set #(.W(NUM_CLASSES), .IW(CW)) u_cls_find (
    .vec    (avail),
    .found  (cls_found),
    .idx    (cls_idx),
    .onehot (cls_onehot)
  );

  assign fcls_ext  = {3'b000, cmd_fcls};
  assign fslot_ext = {1'b0, cmd_fslot};
  assign rd_addr   = (cmd_func == FUNC_FREE) ? fcls_ext[CW-1:0] : cls_idx;

  // unwritten rows read as all free
  assign row = row_valid[sel_class] ? rd_data : '0;

  scpa_first_set #(.W(SLOTS_PER_CLASS), .IW(SW)) u_slot_find (
    .vec    (~row),
    .found  (slot_found),
    .idx    (slot_idx),
    .onehot (slot_onehot)
  );

  assign free_dec = {{(SLOTS_PER_CLASS-1){1'b0}}, 1'b1} << sel_slot;
  assign mod_go   = (state == S_MOD) && !(out_valid && out_stall);

  always_comb begin
    if (cmd_func == FUNC_FREE) begin
      wr_data = row & ~free_dec;
      wr_en   = mod_go && free_ok;
    end else begin
      wr_data = row | slot_onehot;
      wr_en   = mod_go && !sel_none && slot_found;
    end
  end

  assign cls_out_ext = 9'(sel_class);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[sel_class] <= wr_data;
    end
    if (state == S_LOOK) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      class_full <= '0;
      row_valid  <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_MOD;
        end
        S_MOD: begin
          if (mod_go) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (wr_en) begin
        row_valid[sel_class]  <= 1'b1;
        class_full[sel_class] <= (cmd_func == FUNC_ALLOC) && (&wr_data);
      end
    end
  end

  // transaction fields and per-stage payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_func  <= func;
      cmd_size  <= request_size;
      cmd_fcls  <= free_class;
      cmd_fslot <= free_slot;
    end
    if (state == S_LOOK) begin
      sel_class <= rd_addr;
      sel_none  <= !cls_found;
      free_ok   <= (fcls_ext < 9'(NUM_CLASSES)) && (fslot_ext < 7'(SLOTS_PER_CLASS));
      sel_slot  <= fslot_ext[SW-1:0];
    end
    if (mod_go) begin
      if (cmd_func == FUNC_FREE) begin
        status      <= ST_FREED;
        grant_class <= '0;
        grant_slot  <= '0;
      end else if (sel_none || !slot_found) begin
        status      <= ST_NOSPACE;
        grant_class <= '0;
        grant_slot  <= '0;
      end else begin
        status      <= ST_GRANTED;
        grant_class <= cls_out_ext[FieldW-1:0];
        grant_slot  <= FieldW'(slot_idx);
      end
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// testbench for size_class_pool_allocator_unit: directed table, then random traffic
// checked against a slot-map predictor of the pool allocator
// depends on scpa_pkg and the allocator rtl
module tb;
  import scpa_pkg::*;

  localparam int NumClasses   = 64;
  localparam int SlotsPerClass = 64;
  localparam int GranuleShift = 8;
  localparam int IdleLimit    = 2000;
  localparam int HoldCycles   = 250;

  typedef struct packed {
    logic [StatW-1:0]  st;
    logic [FieldW-1:0] cls;
    logic [FieldW-1:0] slot;
  } result_t;

  typedef struct packed {
    logic              fn;
    logic [SizeW-1:0]  bytes;
    logic [FieldW-1:0] fcls;
    logic [FieldW-1:0] fslot;
    logic              typed;
    logic [StatW-1:0]  st;
    logic [FieldW-1:0] cls;
    logic [FieldW-1:0] slot;
  } item_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_stall;
  logic func;
  logic [SizeW-1:0] request_size;
  logic [FieldW-1:0] free_class, free_slot;
  logic out_valid, out_stall;
  logic [StatW-1:0] status;
  logic [FieldW-1:0] grant_class, grant_slot;

  size_class_pool_allocator_unit #(
    .NUM_CLASSES    (NumClasses),
    .SLOTS_PER_CLASS(SlotsPerClass),
    .GRANULE_SHIFT  (GranuleShift)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .request_size(request_size),
    .free_class  (free_class),
    .free_slot   (free_slot),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .grant_class (grant_class),
    .grant_slot  (grant_slot)
  );

  always #5 clk = ~clk;

  bit [63:0] pool_used [NumClasses];
  item_t offered_items [$];
  result_t pending_results [$];
  logic [2*FieldW-1:0] live_handles [$];

  int errors = 0;
  int n_items = 0, n_granted = 0, n_nospace = 0, n_freed = 0;
  int idle_cycles = 0;
  int tx_max = 0, rx_max = 0;
  bit hold_req = 1'b0;

  // directed rows; typed results only where they follow from the rows before, starting from an empty map
  item_t dir_rows [25] = '{
    '{FUNC_ALLOC, 16'd0,     6'd0,  6'd0,  1'b1, ST_GRANTED, 6'd0,  6'd0},
    '{FUNC_ALLOC, 16'd1,     6'd0,  6'd0,  1'b1, ST_GRANTED, 6'd0,  6'd1},
    '{FUNC_ALLOC, 16'd256,   6'd0,  6'd0,  1'b1, ST_GRANTED, 6'd0,  6'd2},
    '{FUNC_ALLOC, 16'd257,   6'd0,  6'd0,  1'b1, ST_GRANTED, 6'd1,  6'd0},
    '{FUNC_ALLOC, 16'd16384, 6'd0,  6'd0,  1'b1, ST_GRANTED, 6'd63, 6'd0},
    '{FUNC_ALLOC, 16'd16385, 6'd0,  6'd0,  1'b1, ST_NOSPACE, 6'd0,  6'd0},
    '{FUNC_ALLOC, 16'hFFFF,  6'd0,  6'd0,  1'b1, ST_NOSPACE, 6'd0,  6'd0},
    '{FUNC_ALLOC, 16'd16129, 6'd0,  6'd0,  1'b1, ST_GRANTED, 6'd63, 6'd1},
    '{FUNC_FREE,  16'd0,     6'd0,  6'd1,  1'b1, ST_FREED,   6'd0,  6'd0},
    '{FUNC_FREE,  16'd0,     6'd0,  6'd1,  1'b1, ST_FREED,   6'd0,  6'd0},
    '{FUNC_ALLOC, 16'd100,   6'd0,  6'd0,  1'b1, ST_GRANTED, 6'd0,  6'd1},
    '{FUNC_FREE,  16'd0,     6'd63, 6'd63, 1'b1, ST_FREED,   6'd0,  6'd0},
    '{FUNC_FREE,  16'd0,     6'd63, 6'd0,  1'b1, ST_FREED,   6'd0,  6'd0},
    '{FUNC_ALLOC, 16'd16200, 6'd0,  6'd0,  1'b1, ST_GRANTED, 6'd63, 6'd0},
    '{FUNC_ALLOC, 16'd512,   6'd0,  6'd0,  1'b1, ST_GRANTED, 6'd1,  6'd1},
    '{FUNC_ALLOC, 16'd513,   6'd0,  6'd0,  1'b1, ST_GRANTED, 6'd2,  6'd0},
    '{FUNC_ALLOC, 16'h8000,  6'd0,  6'd0,  1'b1, ST_NOSPACE, 6'd0,  6'd0},
    '{FUNC_FREE,  16'd0,     6'd1,  6'd0,  1'b1, ST_FREED,   6'd0,  6'd0},
    '{FUNC_ALLOC, 16'd300,   6'd0,  6'd0,  1'b1, ST_GRANTED, 6'd1,  6'd0},
    '{FUNC_ALLOC, 16'd255,   6'd0,  6'd0,  1'b1, ST_GRANTED, 6'd0,  6'd3},
    '{FUNC_ALLOC, 16'hAAAA,  6'd0,  6'd0,  1'b0, ST_GRANTED, 6'd0,  6'd0},
    '{FUNC_ALLOC, 16'h1555,  6'd0,  6'd0,  1'b0, ST_GRANTED, 6'd0,  6'd0},
    '{FUNC_FREE,  16'h5555,  6'h2A, 6'h15, 1'b0, ST_GRANTED, 6'd0,  6'd0},
    '{FUNC_FREE,  16'hAAAA,  6'h15, 6'h2A, 1'b0, ST_GRANTED, 6'd0,  6'd0},
    '{FUNC_ALLOC, 16'h3FFF,  6'd0,  6'd0,  1'b0, ST_GRANTED, 6'd0,  6'd0}
  };

  // applies a free to the slot map, or rounds the size to a class and takes the first free slot from there upward
  function automatic result_t predict_pool_result(logic fn, logic [SizeW-1:0] bytes,
                                                  logic [FieldW-1:0] fc,
                                                  logic [FieldW-1:0] fs);
    result_t r;
    int unsigned sz;
    int unsigned need;
    r = '{ST_NOSPACE, '0, '0};
    if (fn == FUNC_FREE) begin
      if (fc < NumClasses && fs < SlotsPerClass) pool_used[fc][fs] = 1'b0;
      r.st = ST_FREED;
      return r;
    end
    sz = (bytes == '0) ? 1 : bytes;
    need = (sz + (1 << GranuleShift) - 1) >> GranuleShift;
    for (int k = need - 1; k < NumClasses; k++) begin
      for (int s = 0; s < SlotsPerClass; s++) begin
        if (!pool_used[k][s]) begin
          pool_used[k][s] = 1'b1;
          r = '{ST_GRANTED, FieldW'(k), FieldW'(s)};
          return r;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  function automatic item_t alloc_item(logic [SizeW-1:0] bytes);
    item_t it;
    it = '0;
    it.fn = FUNC_ALLOC;
    it.bytes = bytes;
    return it;
  endfunction

  function automatic item_t free_item(logic [FieldW-1:0] fc, logic [FieldW-1:0] fs);
    item_t it;
    it = '0;
    it.fn = FUNC_FREE;
    it.fcls = fc;
    it.fslot = fs;
    it.bytes = SizeW'($urandom);
    return it;
  endfunction

  // called at a rising edge, returns at the edge where the transaction is taken
  task automatic send_item(input item_t it);
    int gap;
    gap = (tx_max == 0) ? 0 : $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offered_items.push_back(it);
    in_valid <= 1'b1;
    func <= it.fn;
    request_size <= it.bytes;
    free_class <= it.fcls;
    free_slot <= it.fslot;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // acceptance, prediction, result check and watchdog share one edge process
  always @(posedge clk) begin
    item_t desc;
    result_t pred, want;
    bit moved;
    if (!rst) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing outstanding, status", status, 0);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.st) report_mismatch("status", status, want.st);
          if (grant_class !== want.cls) report_mismatch("grant_class", grant_class, want.cls);
          if (grant_slot !== want.slot) report_mismatch("grant_slot", grant_slot, want.slot);
          case (want.st)
            ST_GRANTED: n_granted++;
            ST_NOSPACE: n_nospace++;
            default:    n_freed++;
          endcase
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        n_items++;
        desc = offered_items.pop_front();
        pred = predict_pool_result(func, request_size, free_class, free_slot);
        if (pred.st == ST_GRANTED) live_handles.push_back({pred.cls, pred.slot});
        if (desc.typed) pending_results.push_back('{desc.st, desc.cls, desc.slot});
        else pending_results.push_back(pred);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transaction for %0d cycles", IdleLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = HoldCycles;
      end else begin
        n = (rx_max == 0) ? 0 : $urandom_range(0, rx_max);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  initial begin
    int pick;
    int sel;
    int k;
    logic [2*FieldW-1:0] h;
    logic [SizeW-1:0] bytes;
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= FUNC_ALLOC;
    request_size <= '0;
    free_class <= '0;
    free_slot <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    tx_max = 3;
    rx_max = 3;
    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // back to back, fill the top class until it runs dry
    tx_max = 0;
    rx_max = 0;
    repeat (70) send_item(alloc_item(SizeW'($urandom_range(16129, 16384))));

    // mixed traffic with a long result hold-off at the start
    tx_max = 10;
    rx_max = 10;
    hold_req = 1'b1;
    repeat (330) begin
      if ($urandom_range(0, 99) < 60) begin
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
          bytes = SizeW'($urandom_range(0, 65535));
        end else if (sel < 70) begin
          bytes = SizeW'($urandom_range(55 * 256 + 1, 16384));
        end else if (sel < 90) begin
          bytes = SizeW'($urandom_range(0, 2048));
        end else begin
          k = $urandom_range(0, 64);
          bytes = SizeW'(k * 256 + $urandom_range(0, 1));
        end
        send_item(alloc_item(bytes));
      end else if (live_handles.size() > 0 && $urandom_range(0, 99) < 70) begin
        pick = $urandom_range(0, live_handles.size() - 1);
        h = live_handles[pick];
        live_handles.delete(pick);
        send_item(free_item(h[2*FieldW-1:FieldW], h[FieldW-1:0]));
      end else begin
        send_item(free_item(FieldW'($urandom), FieldW'($urandom)));
      end
    end

    // open a few top-class slots, then overfill the class below so it spills up
    rx_max = 2;
    repeat (6) send_item(free_item(6'd63, FieldW'($urandom_range(0, 63))));
    repeat (72) send_item(alloc_item(SizeW'($urandom_range(15873, 16128))));

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("ran %0d transactions: %0d grants, %0d no space, %0d frees", n_items,
             n_granted, n_nospace, n_freed);
    $display("top classes were filled to exhaustion and a %0d cycle output hold was applied",
             HoldCycles);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
